// File: sv/half_duplex_uart_engine_defines.svh
// ----------------------------------------------------------------------------
// UART engine assertion macros
// Shared property forms for the engine's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_UART_ENGINE_DEFINES_SVH
`define HALF_DUPLEX_UART_ENGINE_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define HDUE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define HDUE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hdue_pkg.sv
// ----------------------------------------------------------------------------
// UART engine package
// Types, codes and constants shared by the engine's modules.
// ----------------------------------------------------------------------------
package hdue_pkg;

    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD_RELOAD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SAMPLE_LOAD = CFG_INDEX_W'(1);

    localparam logic [7:0] BIT_PERIOD_RELOAD_RST = 8'd48;
    localparam logic [7:0] START_SAMPLE_LOAD_RST = 8'd152;
    localparam logic [7:0] TX_FAST_LOAD          = 8'hF0;
    localparam logic [7:0] TIMER_WRAP            = 8'hFF;
    localparam logic [3:0] BITS_PER_BYTE         = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_RX_START = 5'b00010,
        PH_RX_DATA  = 5'b00100,
        PH_TX_START = 5'b01000,
        PH_TX_DATA  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       rx_line;
        logic       send_request;
        logic [7:0] send_byte;
    } t_item;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] received_byte;
        logic       receive_done;
        logic       busy_res;
    } t_result;

    typedef struct packed {
        logic [7:0] bit_period_reload;
        logic [7:0] start_sample_load;
    } t_cfg;

endpackage

// File: sv/hdue_in_stage.sv
// ----------------------------------------------------------------------------
// UART engine input stage
// Registers one accepted tick item and offers it to the step logic.
// ----------------------------------------------------------------------------
module hdue_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hdue_pkg::t_item i_item,
    input  logic           i_adv,
    output logic           o_item_valid,
    output hdue_pkg::t_item o_item
);
    import hdue_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_adv;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/hdue_step.sv
// ----------------------------------------------------------------------------
// UART engine step logic
// Holds the transceiver state and works out one tick per advance.
// ----------------------------------------------------------------------------
module hdue_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  hdue_pkg::t_item  i_item,
    input  hdue_pkg::t_cfg   i_cfg,
    output hdue_pkg::t_result o_result
);
    import hdue_pkg::*;

    t_phase     r_phase,   n_phase;
    logic [3:0] r_bit_cnt, n_bit_cnt;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [7:0] r_tx_hold, n_tx_hold;
    logic [7:0] r_timer,   n_timer;
    logic       r_running, n_running;
    logic       r_armed,   n_armed;
    logic       r_prev_rx, n_prev_rx;
    logic       r_line,    n_line;
    logic [7:0] r_last_rx, n_last_rx;
    logic       n_done;
    logic [3:0] w_cnt_inc;
    logic [7:0] w_shift_set;

    assign w_cnt_inc   = r_bit_cnt + 4'd1;
    assign w_shift_set = r_rx_shift | (8'(i_item.rx_line) << r_bit_cnt[2:0]);

    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_rx_shift = r_rx_shift;
        n_tx_hold  = r_tx_hold;
        n_timer    = r_timer;
        n_running  = r_running;
        n_armed    = r_armed;
        n_line     = r_line;
        n_last_rx  = r_last_rx;
        n_done     = 1'b0;
        n_prev_rx  = i_item.rx_line;

        if (r_phase == PH_IDLE) begin
            if (r_armed && r_prev_rx && !i_item.rx_line) begin
                n_timer   = i_cfg.start_sample_load;
                n_running = 1'b1;
                n_armed   = 1'b0;
                n_phase   = PH_RX_START;
            end else if (i_item.send_request) begin
                n_tx_hold = i_item.send_byte;
                n_timer   = TX_FAST_LOAD;
                n_running = 1'b1;
                n_phase   = PH_TX_START;
            end
        end else if (r_running) begin
            if (r_timer == TIMER_WRAP) begin
                n_timer = i_cfg.bit_period_reload;
                unique case (r_phase)
                    PH_RX_START: begin
                        if (!i_item.rx_line) begin
                            n_phase    = PH_RX_DATA;
                            n_bit_cnt  = 4'd0;
                            n_rx_shift = 8'd0;
                        end else begin
                            n_phase   = PH_IDLE;
                            n_running = 1'b0;
                            n_armed   = 1'b1;
                        end
                    end
                    PH_RX_DATA: begin
                        n_rx_shift = w_shift_set;
                        n_bit_cnt  = w_cnt_inc;
                        if (w_cnt_inc >= BITS_PER_BYTE) begin
                            n_last_rx = w_shift_set;
                            n_done    = 1'b1;
                            n_phase   = PH_IDLE;
                            n_running = 1'b0;
                            n_armed   = 1'b1;
                        end
                    end
                    PH_TX_START: begin
                        n_line    = 1'b0;
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_TX_DATA;
                    end
                    PH_TX_DATA: begin
                        if (r_bit_cnt < BITS_PER_BYTE) begin
                            n_line    = r_tx_hold[r_bit_cnt[2:0]];
                            n_bit_cnt = w_cnt_inc;
                        end else begin
                            n_line    = 1'b1;
                            n_phase   = PH_IDLE;
                            n_running = 1'b0;
                            n_armed   = 1'b1;
                        end
                    end
                    default: begin
                        n_phase   = PH_IDLE;
                        n_running = 1'b0;
                        n_armed   = 1'b1;
                    end
                endcase
            end else begin
                n_timer = r_timer + 8'd1;
            end
        end
    end

    assign o_result.tx_line       = n_line;
    assign o_result.received_byte = n_last_rx;
    assign o_result.receive_done  = n_done;
    assign o_result.busy_res      = (n_phase != PH_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= 4'd0;
            r_rx_shift <= 8'd0;
            r_tx_hold  <= 8'd0;
            r_timer    <= 8'd0;
            r_running  <= 1'b0;
            r_armed    <= 1'b1;
            r_prev_rx  <= 1'b1;
            r_line     <= 1'b1;
            r_last_rx  <= 8'd0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_rx_shift <= n_rx_shift;
            r_tx_hold  <= n_tx_hold;
            r_timer    <= n_timer;
            r_running  <= n_running;
            r_armed    <= n_armed;
            r_prev_rx  <= n_prev_rx;
            r_line     <= n_line;
            r_last_rx  <= n_last_rx;
        end
    end

endmodule

// File: sv/hdue_out_stage.sv
// ----------------------------------------------------------------------------
// UART engine result stage
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hdue_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    output logic              o_load_ready,
    input  hdue_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output hdue_pkg::t_result o_result
);
    import hdue_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_load_ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_result     = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_valid && o_load_ready) begin
            r_result <= i_result;
        end
    end

endmodule

// File: sv/half_duplex_uart_engine.sv
// ----------------------------------------------------------------------------
// Half-duplex UART engine
// 8N1 receive and transmit engine driven one prescaled tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one prescaled tick and yields exactly one result
// transfer. The engine takes one tick per clock cycle while results are taken; a
// tick passes an input register, the single-pass tick logic with the transceiver
// state, and a result register. A stalled result holds the pipeline; the
// configuration port is always ready and its writes act at once.
module half_duplex_uart_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_rx_line,
    input  logic                             i_send_request,
    input  logic [7:0]                       i_send_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_tx_line,
    output logic [7:0]                       o_received_byte,
    output logic                             o_receive_done,
    output logic                             o_busy_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hdue_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);
    import hdue_pkg::*;

    `include "half_duplex_uart_engine_defines.svh"

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_load_ready;
    logic    w_adv;
    t_result w_step_result;
    t_result w_out_result;
    t_cfg    r_cfg;

    assign w_in_item.rx_line      = i_rx_line;
    assign w_in_item.send_request = i_send_request;
    assign w_in_item.send_byte    = i_send_byte;
    assign w_adv                  = w_item_valid && w_load_ready;
    assign o_cfg_ready            = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period_reload <= BIT_PERIOD_RELOAD_RST;
            r_cfg.start_sample_load <= START_SAMPLE_LOAD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BIT_PERIOD_RELOAD: r_cfg.bit_period_reload <= i_cfg_data;
                CFG_START_SAMPLE_LOAD: r_cfg.start_sample_load <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hdue_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (w_in_item),
        .i_adv        (w_adv),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    hdue_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_step_result)
    );

    hdue_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_item_valid),
        .o_load_ready (w_load_ready),
        .i_result     (w_step_result),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (w_out_result)
    );

    assign o_tx_line       = w_out_result.tx_line;
    assign o_received_byte = w_out_result.received_byte;
    assign o_receive_done  = w_out_result.receive_done;
    assign o_busy_res      = w_out_result.busy_res;

    `HDUE_ASSERT_NOW(a_done_ends_busy, i_clk, i_rst_n, o_valid && o_receive_done, !o_busy_res, "receive done while still busy")
    `HDUE_ASSERT_NOW(a_tx_low_busy, i_clk, i_rst_n, o_valid && !o_tx_line, o_busy_res, "transmit line low while idle")
    `HDUE_ASSERT_NEXT(a_item_held, i_clk, i_rst_n, w_item_valid && !w_adv, w_item_valid, "registered tick lost while stalled")

endmodule
